// File: rtl/core/dds_pkg.sv
package dds_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_KP             = 3'd0;
  localparam cfg_idx_t CFG_KI             = 3'd1;
  localparam cfg_idx_t CFG_CRUISE_CNT     = 3'd2;
  localparam cfg_idx_t CFG_STEER_OFS      = 3'd3;
  localparam cfg_idx_t CFG_INTEGRAL_LIMIT = 3'd4;
  localparam cfg_idx_t CFG_PWM_LIMIT      = 3'd5;

  // Fixed field widths
  localparam int GAIN_W = 16;
  localparam int LIM_W  = 15;
  localparam int OUT_W  = 16;

  // Register reset values
  localparam logic [GAIN_W-1:0] KP_RST             = 16'd10240;
  localparam logic [GAIN_W-1:0] KI_RST             = 16'd512;
  localparam logic [LIM_W-1:0]  CRUISE_CNT_RST     = 15'd60;
  localparam logic [LIM_W-1:0]  STEER_OFS_RST      = 15'd2500;
  localparam logic [LIM_W-1:0]  INTEGRAL_LIMIT_RST = 15'd4000;
  localparam logic [LIM_W-1:0]  PWM_LIMIT_RST      = 15'd7200;

  typedef struct packed {
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] ki;
    logic [LIM_W-1:0]  cruise_cnt;
    logic [LIM_W-1:0]  steer_ofs;
    logic [LIM_W-1:0]  integral_limit;
    logic [LIM_W-1:0]  pwm_limit;
  } cfg_t;

  // One result word: drive plus the two motor commands
  typedef struct packed {
    logic signed [OUT_W-1:0] drive;
    logic signed [OUT_W-1:0] motor_left;
    logic signed [OUT_W-1:0] motor_right;
  } mix_t;

endpackage

// File: rtl/core/dds_if.sv
interface dds_in_if #(parameter int COUNT_WIDTH = 16);
  logic                          valid;
  logic                          ready;
  logic signed [COUNT_WIDTH-1:0] count_left;
  logic signed [COUNT_WIDTH-1:0] count_right_raw;
  logic                          go_forward;
  logic                          go_backward;
  logic                          turn_left;
  logic                          turn_right;

  modport source (
    output valid, count_left, count_right_raw, go_forward, go_backward,
           turn_left, turn_right,
    input  ready
  );
  modport sink (
    input  valid, count_left, count_right_raw, go_forward, go_backward,
           turn_left, turn_right,
    output ready
  );
endinterface

interface dds_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] drive;
  logic signed [15:0] motor_left;
  logic signed [15:0] motor_right;

  modport source (
    output valid, drive, motor_left, motor_right,
    input  ready
  );
  modport sink (
    input  valid, drive, motor_left, motor_right,
    output ready
  );
endinterface

// File: rtl/core/dds_mix.sv
module dds_mix import dds_pkg::*; #(
  parameter int ACC_W = 51
) (
  input  logic signed [ACC_W-1:0] acc,
  input  logic signed [OUT_W-1:0] turn,
  input  logic [LIM_W-1:0]        pwm_limit,
  output mix_t                    res
);

  localparam int MIX_W = OUT_W + 1;

  logic [ACC_W-1:0]        bias_u;
  logic signed [ACC_W-1:0] biased;
  logic signed [ACC_W-1:0] quot;
  logic signed [ACC_W-1:0] lim_a;
  logic signed [MIX_W-1:0] lim_m;
  logic signed [OUT_W-1:0] drive;
  logic signed [MIX_W-1:0] ml_raw;
  logic signed [MIX_W-1:0] mr_raw;

  // Divide by 256 with truncation toward zero: bias negatives by 255
  assign bias_u = {{(ACC_W-8){1'b0}}, {8{acc[ACC_W-1]}}};
  assign biased = acc + $signed(bias_u);
  assign quot   = biased >>> 8;

  assign lim_a = ACC_W'($signed({1'b0, pwm_limit}));
  assign lim_m = MIX_W'($signed({1'b0, pwm_limit}));

  always_comb begin
    if (quot > lim_a) begin
      drive = OUT_W'(lim_a);
    end else if (quot < -lim_a) begin
      drive = OUT_W'(-lim_a);
    end else begin
      drive = OUT_W'(quot);
    end
  end

  assign ml_raw = MIX_W'(drive) - MIX_W'(turn);
  assign mr_raw = MIX_W'(drive) + MIX_W'(turn);

  always_comb begin
    res.drive = drive;
    if (ml_raw > lim_m) begin
      res.motor_left = OUT_W'(lim_m);
    end else if (ml_raw < -lim_m) begin
      res.motor_left = OUT_W'(-lim_m);
    end else begin
      res.motor_left = OUT_W'(ml_raw);
    end
    if (mr_raw > lim_m) begin
      res.motor_right = OUT_W'(lim_m);
    end else if (mr_raw < -lim_m) begin
      res.motor_right = OUT_W'(-lim_m);
    end else begin
      res.motor_right = OUT_W'(mr_raw);
    end
  end

endmodule

// File: rtl/core/differential_drive_pi_speed_unit.sv
// PI speed controller for a two-wheel differential drive. Each input word is one
// control tick (both encoder counts plus the four command bits); each output word
// carries the clamped drive and the left/right motor PWM. The block takes one word
// per clock while the output is not held off; each word passes through the input
// register, error/integral stage, multiplier stage, accumulate stage and output
// register in that order. The integral updates as a word leaves the input register,
// so ticks follow each other with no gap. Stages collapse bubbles independently, so
// the block keeps taking words while a finished result waits on the output, until
// every stage holds a word. Write configuration only while no word is in flight.
module differential_drive_pi_speed_unit import dds_pkg::*; #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  dds_in_if.sink                in_ch,
  dds_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  cfg_idx_t              cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int SUM_W  = COUNT_WIDTH + 1;
  localparam int ERR_W  = ((SUM_W > OUT_W) ? SUM_W : OUT_W) + 1;
  localparam int INTS_W = ERR_W + 1;
  localparam int PRD_W  = ERR_W + GAIN_W + 1;
  localparam int ACC_W  = PRD_W + 1;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kp             <= KP_RST;
      cfg_r.ki             <= KI_RST;
      cfg_r.cruise_cnt     <= CRUISE_CNT_RST;
      cfg_r.steer_ofs      <= STEER_OFS_RST;
      cfg_r.integral_limit <= INTEGRAL_LIMIT_RST;
      cfg_r.pwm_limit      <= PWM_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_KP:             cfg_r.kp             <= cfg_wdata;
        CFG_KI:             cfg_r.ki             <= cfg_wdata;
        CFG_CRUISE_CNT:     cfg_r.cruise_cnt     <= cfg_wdata[LIM_W-1:0];
        CFG_STEER_OFS:      cfg_r.steer_ofs      <= cfg_wdata[LIM_W-1:0];
        CFG_INTEGRAL_LIMIT: cfg_r.integral_limit <= cfg_wdata[LIM_W-1:0];
        CFG_PWM_LIMIT:      cfg_r.pwm_limit      <= cfg_wdata[LIM_W-1:0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control: each stage loads when empty or when it drains
  // ---------------------------------------------------------------------------
  logic a_v_r, b_v_r, p_v_r, s_v_r, out_v_r;
  logic a_ld, b_ld, p_ld, s_ld, out_ld;
  logic mv_ab;

  assign out_ld      = !out_v_r || out_ch.ready;
  assign s_ld        = !s_v_r || out_ld;
  assign p_ld        = !p_v_r || s_ld;
  assign b_ld        = !b_v_r || p_ld;
  assign a_ld        = !a_v_r || b_ld;
  assign in_ch.ready = a_ld;
  assign mv_ab       = a_v_r && b_ld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r   <= 1'b0;
      b_v_r   <= 1'b0;
      p_v_r   <= 1'b0;
      s_v_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (a_ld)   a_v_r   <= in_ch.valid;
      if (b_ld)   b_v_r   <= a_v_r;
      if (p_ld)   p_v_r   <= b_v_r;
      if (s_ld)   s_v_r   <= p_v_r;
      if (out_ld) out_v_r <= s_v_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage A: input register
  // ---------------------------------------------------------------------------
  logic signed [COUNT_WIDTH-1:0] a_cl_r, a_cr_r;
  logic                          a_fwd_r, a_back_r, a_tl_r, a_tr_r;

  always_ff @(posedge clk) begin
    if (a_ld && in_ch.valid) begin
      a_cl_r   <= in_ch.count_left;
      a_cr_r   <= in_ch.count_right_raw;
      a_fwd_r  <= in_ch.go_forward;
      a_back_r <= in_ch.go_backward;
      a_tl_r   <= in_ch.turn_left;
      a_tr_r   <= in_ch.turn_right;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage A -> B: speed error, integral update and turn offset
  // ---------------------------------------------------------------------------
  logic signed [OUT_W-1:0]  integ_r, integ_nxt;
  logic signed [SUM_W-1:0]  cnt_sum;
  logic signed [OUT_W-1:0]  target;
  logic signed [OUT_W-1:0]  turn;
  logic signed [ERR_W-1:0]  err;
  logic signed [INTS_W-1:0] integ_sum;
  logic signed [INTS_W-1:0] ilim;

  // Right count arrives negated, so the count sum is left minus raw right
  assign cnt_sum = SUM_W'(a_cl_r) - SUM_W'(a_cr_r);

  always_comb begin
    priority if (a_fwd_r) begin
      target = $signed({1'b0, cfg_r.cruise_cnt});
    end else if (a_back_r) begin
      target = -$signed({1'b0, cfg_r.cruise_cnt});
    end else begin
      target = '0;
    end
  end

  always_comb begin
    priority if (a_tl_r) begin
      turn = $signed({1'b0, cfg_r.steer_ofs});
    end else if (a_tr_r) begin
      turn = -$signed({1'b0, cfg_r.steer_ofs});
    end else begin
      turn = '0;
    end
  end

  assign err       = ERR_W'(target) - ERR_W'(cnt_sum);
  assign integ_sum = INTS_W'(integ_r) + INTS_W'(err);
  assign ilim      = INTS_W'($signed({1'b0, cfg_r.integral_limit}));

  // Clamp the accumulated error symmetrically
  always_comb begin
    if (integ_sum > ilim) begin
      integ_nxt = OUT_W'(ilim);
    end else if (integ_sum < -ilim) begin
      integ_nxt = OUT_W'(-ilim);
    end else begin
      integ_nxt = OUT_W'(integ_sum);
    end
  end

  // Advance the integral only as a word moves on, so ticks stay in order
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
    end else if (mv_ab) begin
      integ_r <= integ_nxt;
    end
  end

  logic signed [ERR_W-1:0] b_err_r;
  logic signed [OUT_W-1:0] b_integ_r;
  logic signed [OUT_W-1:0] b_turn_r;

  always_ff @(posedge clk) begin
    if (mv_ab) begin
      b_err_r   <= err;
      b_integ_r <= integ_nxt;
      b_turn_r  <= turn;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage B -> P: gain products
  // ---------------------------------------------------------------------------
  logic signed [GAIN_W:0]  kp_s, ki_s;
  logic signed [PRD_W-1:0] p_prop_r, p_intg_r;
  logic signed [OUT_W-1:0] p_turn_r;

  assign kp_s = $signed({1'b0, cfg_r.kp});
  assign ki_s = $signed({1'b0, cfg_r.ki});

  always_ff @(posedge clk) begin
    if (p_ld && b_v_r) begin
      p_prop_r <= PRD_W'(kp_s) * PRD_W'(b_err_r);
      p_intg_r <= PRD_W'(ki_s) * PRD_W'(b_integ_r);
      p_turn_r <= b_turn_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage P -> S: sum of both terms (signed Q28.8 before scaling)
  // ---------------------------------------------------------------------------
  logic signed [ACC_W-1:0] s_acc_r;
  logic signed [OUT_W-1:0] s_turn_r;

  always_ff @(posedge clk) begin
    if (s_ld && p_v_r) begin
      s_acc_r  <= ACC_W'(p_prop_r) + ACC_W'(p_intg_r);
      s_turn_r <= p_turn_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage S -> output: scale, clamp and split into the two motors
  // ---------------------------------------------------------------------------
  mix_t mix_res;
  mix_t out_word_r;

  dds_mix #(
    .ACC_W (ACC_W)
  ) u_mix (
    .acc       (s_acc_r),
    .turn      (s_turn_r),
    .pwm_limit (cfg_r.pwm_limit),
    .res       (mix_res)
  );

  always_ff @(posedge clk) begin
    if (out_ld && s_v_r) begin
      out_word_r <= mix_res;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.drive       = out_word_r.drive;
  assign out_ch.motor_left  = out_word_r.motor_left;
  assign out_ch.motor_right = out_word_r.motor_right;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  logic signed [OUT_W-1:0] plim_s;
  assign plim_s = $signed({1'b0, cfg_r.pwm_limit});

  // Integral lands inside the limit in force when it was updated
  a_integ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    mv_ab |=> (integ_r <= $signed({1'b0, $past(cfg_r.integral_limit)}) &&
               integ_r >= -$signed({1'b0, $past(cfg_r.integral_limit)})))
    else $error("integral outside its clamp");

  // Integral holds unless a word moves out of the input register
  a_integ_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !mv_ab |=> $stable(integ_r))
    else $error("integral changed without a word");

  // Every delivered command respects the PWM clamp
  a_out_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_word_r.drive <= plim_s && out_word_r.drive >= -plim_s &&
                 out_word_r.motor_left <= plim_s && out_word_r.motor_left >= -plim_s &&
                 out_word_r.motor_right <= plim_s && out_word_r.motor_right >= -plim_s))
    else $error("output beyond pwm limit");

endmodule
